@@ rtl/barc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barc_pkg
// Shared widths, register indexes and result type of the bit aligned row copy.
// ----------------------------------------------------------------------------
package barc_pkg;

    localparam int WORD_W      = 32;
    localparam int OFFSET_W    = 5;
    localparam int BIT_COUNT_W = 13;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BIT_OFFSET = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_BIT_OFFSET = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING     = 8'd3;

    // output queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [WORD_W-1:0] dst_word;
        logic [WORD_W-1:0] write_mask;
        logic              row_last;
    } barc_result_t;

endpackage

@@ rtl/barc_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barc_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface barc_cfg_if;
    import barc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/barc_src_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barc_src_if
// Source word stream, one 32-bit word per transfer.
// ----------------------------------------------------------------------------
interface barc_src_if;
    import barc_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] src_word;

    modport source (output valid, output src_word, input ready);
    modport sink   (input valid, input src_word, output ready);
endinterface

@@ rtl/barc_dst_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barc_dst_if
// Destination word stream with bit write mask and end of row flag.
// ----------------------------------------------------------------------------
interface barc_dst_if;
    import barc_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] dst_word;
    logic [WORD_W-1:0] write_mask;
    logic              row_last;

    modport source (output valid, output dst_word, output write_mask, output row_last,
                    input ready);
    modport sink   (input valid, input dst_word, input write_mask, input row_last,
                    output ready);
endinterface

@@ rtl/bit_aligned_row_copy_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_aligned_row_copy_core
// Blitter row engine: funnel-shifts a stream of source words into destination
// words at another bit offset, with a write mask for partial edge words.
//
// cfg: register writes (source offset, destination offset, bit count,
//   descending), always ready; a write to a listed register rearms the row.
// src: source words of a row in walking order, one per transfer.
// dst: destination words with write mask; row_last flags the final word.
// Each accepted source word is worked on in the accepting cycle and its
// results land in a four entry output queue, from which dst is offered, so
// dst is driven from registers. One source word per cycle is sustained while
// the receiver keeps up and no register write is offered; the last word of a
// row may push a second, flushed result. src.ready is high while the queue has
// room for two results and no register write is offered, so a stalled receiver
// holds src off, no result is lost and a register write never meets a source
// transfer in the same cycle.
// Reset clears the registers to their defaults, empties the queue and
// rearms the row.
// ----------------------------------------------------------------------------
module bit_aligned_row_copy_core
    import barc_pkg::*;
#(
    parameter int MAX_ROW_BITS = 4096
)(
    input  logic      clk,
    input  logic      rst_n,
    barc_cfg_if.sink  cfg,
    barc_src_if.sink  src,
    barc_dst_if.source dst
);

    localparam int CW    = $clog2(MAX_ROW_BITS + 1);
    localparam int EW    = CW + 2;
    localparam int MAXW  = (MAX_ROW_BITS + 62) / 32;
    localparam int NW    = $clog2(MAXW + 1);

    // configuration registers
    logic [OFFSET_W-1:0]    src_bit_offset_reg;
    logic [OFFSET_W-1:0]    dst_bit_offset_reg;
    logic [BIT_COUNT_W-1:0] bit_count_reg;
    logic                   descending_reg;

    // row state
    logic [WORD_W-1:0] held_word_reg, held_word_next;
    logic [NW-1:0]     seen_reg, seen_next;
    logic [NW-1:0]     sent_reg, sent_next;

    // output queue
    barc_result_t              queue_reg [QDEPTH];
    barc_result_t              queue_next [QDEPTH];
    logic [QPTR_W-1:0]         head_reg, head_next;
    logic [QCNT_W-1:0]         count_reg, count_next;

    logic              cfg_xfer;
    logic              src_xfer;
    logic              dst_xfer;
    logic [EW-1:0]     cnt;
    logic [EW-1:0]     sxc;
    logic [EW-1:0]     dxc;
    logic [NW-1:0]     nsrc;
    logic [NW-1:0]     ndst;
    logic [OFFSET_W-1:0] sh;
    logic              lagged;
    logic              emit0;
    logic              emit1;
    logic              row_end;
    logic [NW-1:0]     seen_inc;
    logic [NW-1:0]     sent1;
    barc_result_t      res0;
    barc_result_t      res1;
    logic [QPTR_W-1:0] tail;

    function automatic logic [WORD_W-1:0] funnel(
        input logic [WORD_W-1:0]   older,
        input logic [WORD_W-1:0]   newer,
        input logic [OFFSET_W-1:0] amt,
        input logic                desc
    );
        logic [2*WORD_W-1:0] cat;
        logic [OFFSET_W:0]   rsh;
        if (desc)
        begin
            cat = {older, newer};
            rsh = 6'd32 - {1'b0, amt};
        end
        else
        begin
            cat = {newer, older};
            rsh = {1'b0, amt};
        end
        cat = cat >> rsh;
        return cat[WORD_W-1:0];
    endfunction

    // mask of destination word k; e is the end bit of the row relative to word k
    function automatic logic [WORD_W-1:0] edge_mask(
        input logic [NW-1:0]       k,
        input logic [OFFSET_W-1:0] dx,
        input logic [EW-1:0]       dx_cnt,
        input logic                desc
    );
        logic [OFFSET_W-1:0] lb;
        logic [EW-1:0]       e;
        logic                full;
        logic [WORD_W-1:0]   m;
        lb   = (k == '0) ? dx : '0;
        e    = dx_cnt - (EW'(k) << 5);
        full = (e >= EW'(32));
        if (desc)
        begin
            m = {WORD_W{1'b1}} >> lb;
            if (!full)
                m = m & ~({WORD_W{1'b1}} >> e[OFFSET_W-1:0]);
        end
        else
        begin
            m = {WORD_W{1'b1}} << lb;
            if (!full)
                m = m & ~({WORD_W{1'b1}} << e[OFFSET_W-1:0]);
        end
        return m;
    endfunction

    assign cfg.ready = 1'b1;
    assign cfg_xfer  = cfg.valid && cfg.ready;
    // a pending register write takes the cycle
    assign src.ready = (count_reg <= QCNT_W'(QDEPTH - 2)) && !cfg.valid;
    assign src_xfer  = src.valid && src.ready;

    assign dst.valid      = (count_reg != '0);
    assign dst.dst_word   = queue_reg[head_reg].dst_word;
    assign dst.write_mask = queue_reg[head_reg].write_mask;
    assign dst.row_last   = queue_reg[head_reg].row_last;
    assign dst_xfer       = dst.valid && dst.ready;

    // effective row geometry
    always_comb
    begin
        if (bit_count_reg == '0)
            cnt = EW'(1);
        else if (32'(bit_count_reg) > 32'(MAX_ROW_BITS))
            cnt = EW'(MAX_ROW_BITS);
        else
            cnt = EW'(bit_count_reg);
        sxc    = EW'(src_bit_offset_reg) + cnt;
        dxc    = EW'(dst_bit_offset_reg) + cnt;
        nsrc   = NW'((sxc + EW'(31)) >> 5);
        ndst   = NW'((dxc + EW'(31)) >> 5);
        lagged = (src_bit_offset_reg >= dst_bit_offset_reg);
        sh     = src_bit_offset_reg - dst_bit_offset_reg;
    end

    always_comb
    begin
        emit0    = (!lagged || seen_reg != '0) && (sent_reg < ndst);
        seen_inc = seen_reg + NW'(1);
        sent1    = sent_reg + NW'(emit0);
        row_end  = (seen_inc >= nsrc);
        emit1    = row_end && (sent1 < ndst);

        res0.dst_word   = funnel(held_word_reg, src.src_word, sh, descending_reg);
        res0.write_mask = edge_mask(sent_reg, dst_bit_offset_reg, dxc, descending_reg);
        res0.row_last   = (sent_reg + NW'(1) == ndst);
        // flush: words past the row read as zero
        res1.dst_word   = funnel(src.src_word, '0, sh, descending_reg);
        res1.write_mask = edge_mask(sent1, dst_bit_offset_reg, dxc, descending_reg);
        res1.row_last   = (sent1 + NW'(1) == ndst);
    end

    always_comb
    begin
        held_word_next = held_word_reg;
        seen_next      = seen_reg;
        sent_next      = sent_reg;
        queue_next     = queue_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        tail           = head_reg + count_reg[QPTR_W-1:0];

        if (cfg_xfer)
        begin
            if (cfg.index <= CFG_DESCENDING)
            begin
                held_word_next = '0;
                seen_next      = '0;
                sent_next      = '0;
            end
        end
        else if (src_xfer)
        begin
            if (row_end)
            begin
                held_word_next = '0;
                seen_next      = '0;
                sent_next      = '0;
            end
            else
            begin
                held_word_next = src.src_word;
                seen_next      = seen_inc;
                sent_next      = sent1;
            end
            if (emit0)
            begin
                queue_next[tail] = res0;
                if (emit1)
                    queue_next[tail + QPTR_W'(1)] = res1;
            end
            else if (emit1)
            begin
                queue_next[tail] = res1;
            end
            count_next = count_reg + QCNT_W'(emit0) + QCNT_W'(emit1);
        end

        if (dst_xfer)
        begin
            head_next  = head_reg + QPTR_W'(1);
            count_next = count_next - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_bit_offset_reg <= '0;
            dst_bit_offset_reg <= '0;
            bit_count_reg      <= BIT_COUNT_W'(1);
            descending_reg     <= 1'b0;
            held_word_reg      <= '0;
            seen_reg           <= '0;
            sent_reg           <= '0;
            head_reg           <= '0;
            count_reg          <= '0;
        end
        else
        begin
            if (cfg_xfer)
            begin
                case (cfg.index)
                    CFG_SRC_BIT_OFFSET: src_bit_offset_reg <= cfg.data[OFFSET_W-1:0];
                    CFG_DST_BIT_OFFSET: dst_bit_offset_reg <= cfg.data[OFFSET_W-1:0];
                    CFG_BIT_COUNT:      bit_count_reg      <= cfg.data[BIT_COUNT_W-1:0];
                    CFG_DESCENDING:     descending_reg     <= cfg.data[0];
                    default:            ;
                endcase
            end
            held_word_reg <= held_word_next;
            seen_reg      <= seen_next;
            sent_reg      <= sent_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    // queue payload carries no reset
    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("output queue overflow");

    a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg <= ndst)
        else $error("more destination words sent than the row holds");

    a_seen_step: assert property (@(posedge clk) disable iff (!rst_n)
        src_xfer && !cfg_xfer && !row_end |=> seen_reg == $past(seen_reg) + NW'(1))
        else $error("source word count did not advance");

    a_row_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        src_xfer && !cfg_xfer && row_end |=> seen_reg == '0 && sent_reg == '0
            && held_word_reg == '0)
        else $error("row state not rearmed at end of row");

endmodule
